>>> src/fwrm_pkg.sv
// fwrm_pkg: beat payload types, command and status codes, and the
// controller/datapath handshake structs of the fenwick range map.
// No dependencies.
`default_nettype none

package fwrm_pkg;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_PREFIX = 3'd3;
    localparam logic [2:0] CMD_FIND   = 3'd4;
    localparam logic [2:0] CMD_TOTAL  = 3'd5;
    localparam logic [2:0] CMD_POP    = 3'd6;
    localparam logic [2:0] CMD_CLEAR  = 3'd7;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ZERO   = 3'd1;
    localparam logic [2:0] ST_BAD    = 3'd2;
    localparam logic [2:0] ST_OFFSET = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;
    localparam logic [2:0] ST_EMPTY  = 3'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  entry_index;
        logic [31:0] width_value;
        logic [31:0] offset;
    } fw_in_t;

    typedef struct packed {
        logic [9:0]  result_index;
        logic [31:0] result_value;
        logic [10:0] entry_count;
        logic [2:0]  status;
    } fw_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic use_rd;
        logic wr;
        logic srch_init;
        logic fin;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       err;
        logic       more;
        logic       big;
        logic       srch;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> src/fwrm_datapath.sv
// fwrm_datapath: node memory, walk registers and result register.
// Depends on fwrm_pkg; sequenced by fwrm_ctrl.
`default_nettype none

module fwrm_datapath
    import fwrm_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int SUM_BITS = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire fw_in_t   in_data,
    input  wire ctl_cmd_t cmd,
    output dp_stat_t      stat,
    output fw_out_t       out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int PW    = CNT_W + 1;
    localparam int HW    = AW + 1;
    localparam int CW    = (CNT_W > 10) ? CNT_W : 10;
    localparam int OW    = (SUM_BITS > 32) ? SUM_BITS : 32;
    localparam logic [HW-1:0] TOP = {1'b1, {AW{1'b0}}};

    logic [SUM_BITS-1:0] node_mem [CAPACITY];

    logic [2:0]          op_reg;
    logic [9:0]          idx_reg;
    logic [SUM_BITS-1:0] wv_reg;
    logic [31:0]         off_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [PW-1:0]       pos_reg;
    logic [PW-1:0]       bit_reg;
    logic [SUM_BITS-1:0] acc_reg;
    logic [SUM_BITS-1:0] rdata_reg;
    logic [HW-1:0]       height_reg;
    logic [CNT_W-1:0]    found_reg;
    logic                first_reg;
    logic                srch_reg;
    fw_out_t             out_reg;

    logic [PW-1:0]       count_p;
    logic                bad, wz, full, empty, skip, ge_ml, big, more, err;
    logic [HW-1:0]       half;
    logic [PW-1:0]       mid;
    logic [PW-1:0]       addr_full;
    logic [AW-1:0]       addr;
    logic [SUM_BITS-1:0] ml;
    logic [2:0]          st_code;
    logic [CNT_W-1:0]    count_next;
    fw_out_t             out_next;

    always_comb begin
        count_p = PW'(count_reg);
        bad     = CW'(idx_reg) >= CW'(count_reg);
        wz      = (wv_reg == '0);
        full    = (count_reg >= CNT_W'(CAPACITY));
        empty   = (count_reg == '0);
        half    = height_reg >> 1;
        mid     = PW'(found_reg) + PW'(half);
        skip    = (mid >= count_p);
        ml      = acc_reg + rdata_reg;
        big     = OW'(off_reg) >= OW'(acc_reg);
        ge_ml   = OW'(off_reg) >= OW'(ml);

        case (op_reg)
            CMD_PUSH:   more = |(pos_reg & bit_reg);
            CMD_READ:   more = first_reg | (|(pos_reg & bit_reg));
            CMD_ADD:    more = (pos_reg < count_p);
            CMD_PREFIX: more = (pos_reg != '0);
            CMD_TOTAL:  more = (pos_reg != '0);
            CMD_FIND:   more = srch_reg ? (height_reg > HW'(1)) : (pos_reg != '0);
            default:    more = 1'b0;
        endcase

        case (op_reg)
            // the new node itself sits at count
            CMD_PUSH:   addr_full = cmd.wr ? pos_reg : (pos_reg ^ bit_reg);
            CMD_READ:   addr_full = first_reg ? pos_reg : (pos_reg ^ bit_reg);
            CMD_ADD:    addr_full = pos_reg;
            CMD_FIND:   addr_full = srch_reg ? (mid - PW'(1)) : (pos_reg - PW'(1));
            default:    addr_full = pos_reg - PW'(1);
        endcase
        addr = addr_full[AW-1:0];

        case (op_reg)
            CMD_PUSH:   st_code = wz ? ST_ZERO : (full ? ST_FULL : ST_OK);
            CMD_ADD:    st_code = wz ? ST_ZERO : (bad ? ST_BAD : ST_OK);
            CMD_READ:   st_code = bad ? ST_BAD : ST_OK;
            CMD_PREFIX: st_code = bad ? ST_BAD : ST_OK;
            CMD_FIND:   st_code = srch_reg ? ST_OK : ST_OFFSET;
            CMD_POP:    st_code = empty ? ST_EMPTY : ST_OK;
            default:    st_code = ST_OK;
        endcase
        // find is judged after the total walk, not up front
        err = (op_reg != CMD_FIND) && (st_code != ST_OK);

        count_next = count_reg;
        out_next   = '0;
        out_next.status = st_code;
        if (st_code == ST_OK) begin
            case (op_reg)
                CMD_PUSH: begin
                    count_next = count_reg + CNT_W'(1);
                    out_next.result_index = 10'(count_reg);
                end
                CMD_POP:    count_next = count_reg - CNT_W'(1);
                CMD_CLEAR:  count_next = '0;
                CMD_FIND: begin
                    out_next.result_index = 10'(found_reg);
                    out_next.result_value = 32'(acc_reg);
                end
                CMD_READ:   out_next.result_value = 32'(acc_reg);
                CMD_PREFIX: out_next.result_value = 32'(acc_reg);
                CMD_TOTAL:  out_next.result_value = 32'(acc_reg);
                default:    count_next = count_reg;
            endcase
        end
        out_next.entry_count = 11'(count_next);
    end

    assign stat.op   = op_reg;
    assign stat.err  = err;
    assign stat.more = more;
    assign stat.big  = big;
    assign stat.srch = srch_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.fin) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rdata_reg <= node_mem[addr];
        end
        if (cmd.wr) begin
            node_mem[addr] <= (op_reg == CMD_PUSH) ? acc_reg : (rdata_reg + wv_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            out_reg <= out_next;
        end
        if (cmd.load) begin
            op_reg     <= in_data.command;
            idx_reg    <= in_data.entry_index;
            wv_reg     <= SUM_BITS'(in_data.width_value);
            off_reg    <= in_data.offset;
            bit_reg    <= PW'(1);
            first_reg  <= (in_data.command == CMD_READ);
            srch_reg   <= 1'b0;
            found_reg  <= '0;
            height_reg <= TOP;
            if (in_data.command == CMD_ADD || in_data.command == CMD_READ ||
                in_data.command == CMD_PREFIX) begin
                pos_reg <= PW'(in_data.entry_index);
            end else begin
                pos_reg <= count_p;
            end
            acc_reg <= (in_data.command == CMD_PUSH) ? SUM_BITS'(in_data.width_value) : '0;
        end else if (cmd.srch_init) begin
            srch_reg   <= 1'b1;
            acc_reg    <= '0;
            found_reg  <= '0;
            height_reg <= TOP;
        end else if (cmd.use_rd) begin
            case (op_reg)
                CMD_PUSH: begin
                    acc_reg <= acc_reg + rdata_reg;
                    bit_reg <= bit_reg << 1;
                end
                CMD_READ: begin
                    if (first_reg) begin
                        acc_reg   <= rdata_reg;
                        first_reg <= 1'b0;
                    end else begin
                        acc_reg <= acc_reg - rdata_reg;
                        bit_reg <= bit_reg << 1;
                    end
                end
                CMD_FIND: begin
                    if (srch_reg) begin
                        // probes at or beyond count are passed over
                        if (!skip && ge_ml) begin
                            found_reg <= mid[CNT_W-1:0];
                            acc_reg   <= ml;
                        end
                        height_reg <= half;
                    end else begin
                        acc_reg <= acc_reg + rdata_reg;
                        pos_reg <= pos_reg & (pos_reg - PW'(1));
                    end
                end
                CMD_PREFIX, CMD_TOTAL: begin
                    acc_reg <= acc_reg + rdata_reg;
                    pos_reg <= pos_reg & (pos_reg - PW'(1));
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end else if (cmd.wr && op_reg == CMD_ADD) begin
            // next node up the update chain
            pos_reg <= pos_reg | (pos_reg + PW'(1));
        end
    end

endmodule

`default_nettype wire

>>> src/fwrm_ctrl.sv
// fwrm_ctrl: command sequencer for the fenwick range map.
// Depends on fwrm_pkg; drives fwrm_datapath.
`default_nettype none

module fwrm_ctrl
    import fwrm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_RD    = 6'b000100,
        S_USE   = 6'b001000,
        S_WR    = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.err || stat.op == CMD_POP || stat.op == CMD_CLEAR) begin
                    state_next = S_FIN;
                end else if (stat.more) begin
                    state_next = S_RD;
                end else if (stat.op == CMD_PUSH) begin
                    state_next = S_WR;
                end else if (stat.op == CMD_FIND && !stat.srch && !stat.big) begin
                    // total known and offset in range: start the descent
                    cmd.srch_init = 1'b1;
                    state_next    = S_RD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_USE;
            end
            S_USE: begin
                cmd.use_rd = 1'b1;
                state_next = (stat.op == CMD_ADD) ? S_WR : S_CHECK;
            end
            S_WR: begin
                cmd.wr     = 1'b1;
                state_next = (stat.op == CMD_PUSH) ? S_FIN : S_CHECK;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.fin      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> src/fenwick_range_map.sv
// fenwick_range_map: one command beat in, one result beat out, one at a time.
// Every node access goes through the single node memory port: a read state and a use
// state plus a decision state, and a write state for push and add. Find walks
// popcount(count) nodes for the total, then log2(CAPACITY) probes.
// Reset clears the entry count and the handshake; node memory is not cleared.
`default_nettype none

module fenwick_range_map
    import fwrm_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int SUM_BITS = 32
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire fw_in_t s_data,
    output logic        m_valid,
    input  wire logic   m_ready,
    output fw_out_t     m_data
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    fwrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fwrm_datapath #(
        .CAPACITY (CAPACITY),
        .SUM_BITS (SUM_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_data)
    );

endmodule

`default_nettype wire

>>> test/tb.sv
// tb: self-checking bench for fenwick_range_map; drives command beats, predicts
// each result with a flat model of the width list and checks every result beat.
// Depends on fwrm_pkg and fenwick_range_map.
`timescale 1ns / 100ps

module tb
    import fwrm_pkg::*;
();

    localparam int CAP = 1024;
    localparam int QUIET_LIMIT = 20000;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    fw_in_t  s_data = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    fw_out_t m_data;

    fenwick_range_map u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // widths held flat; sums recomputed each time
    logic [31:0] widths[CAP];
    int          n_entries = 0;
    fw_out_t     pending_results[$];
    int          err_count = 0;
    int          quiet_cycles = 0;
    bit          hold_sink = 0;
    bit          sink_free = 0;

    function automatic logic [31:0] sum_below(int pos);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < pos; i++) acc += widths[i];
        return acc;
    endfunction

    function automatic fw_out_t predict_result(fw_in_t cmd);
        fw_out_t r;
        logic [31:0] acc;
        r = '0;
        case (cmd.command)
            CMD_PUSH: begin
                if (cmd.width_value == 0) r.status = ST_ZERO;
                else if (n_entries >= CAP) r.status = ST_FULL;
                else begin
                    widths[n_entries] = cmd.width_value;
                    r.result_index = 10'(n_entries);
                    n_entries++;
                end
            end
            CMD_ADD: begin
                if (cmd.width_value == 0) r.status = ST_ZERO;
                else if (cmd.entry_index >= n_entries) r.status = ST_BAD;
                else widths[cmd.entry_index] += cmd.width_value;
            end
            CMD_READ: begin
                if (cmd.entry_index >= n_entries) r.status = ST_BAD;
                else r.result_value = widths[cmd.entry_index];
            end
            CMD_PREFIX: begin
                if (cmd.entry_index >= n_entries) r.status = ST_BAD;
                else r.result_value = sum_below(cmd.entry_index);
            end
            CMD_FIND: begin
                if (cmd.offset >= sum_below(n_entries)) r.status = ST_OFFSET;
                else begin
                    // wrapped sums: walk in tree order like the block does
                    int h, found;
                    logic [31:0] left, ml;
                    h = 1; found = 0; left = '0;
                    while (h < n_entries) h <<= 1;
                    for (; h > 1; h >>= 1) begin
                        int mid;
                        mid = found + (h >> 1);
                        if (mid < n_entries) begin
                            ml = sum_below(mid);
                            if (cmd.offset >= ml) begin
                                found = mid;
                                left = ml;
                            end
                        end
                    end
                    r.result_index = 10'(found);
                    r.result_value = left;
                end
            end
            CMD_TOTAL: r.result_value = sum_below(n_entries);
            CMD_POP: begin
                if (n_entries == 0) r.status = ST_EMPTY;
                else n_entries--;
            end
            default: n_entries = 0;
        endcase
        r.entry_count = 11'(n_entries);
        return r;
    endfunction

    // result checker, sampling at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            fw_out_t want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.result_index !== want.result_index) begin
                    $error("result_index exp %0d got %0d", want.result_index,
                           m_data.result_index);
                    err_count++;
                end
                if (m_data.result_value !== want.result_value) begin
                    $error("result_value exp %0h got %0h", want.result_value,
                           m_data.result_value);
                    err_count++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $error("entry_count exp %0d got %0d", want.entry_count,
                           m_data.entry_count);
                    err_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, m_data.status);
                    err_count++;
                end
            end
        end
    end

    // watchdog on accepted beats
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern, plus a long forced hold-off
    always @(negedge aclk) begin
        if (hold_sink) m_ready <= 1'b0;
        else if (sink_free) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_beat(logic [2:0] op, logic [9:0] idx, logic [31:0] wv,
                             logic [31:0] off);
        fw_in_t  beat;
        fw_out_t exp_r;
        beat.command = op;
        beat.entry_index = idx;
        beat.width_value = wv;
        beat.offset = off;
        s_data = beat;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_r = predict_result(beat);
        pending_results.insert(pending_results.size(), exp_r);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_width();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 255);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_beat(CMD_POP, 0, 0, 0);
        send_beat(CMD_FIND, 0, 0, 0);
        send_beat(CMD_TOTAL, 0, 0, 0);
        send_beat(CMD_READ, 0, 0, 0);
        send_beat(CMD_PUSH, 0, 0, 0);
        send_beat(CMD_PUSH, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_PUSH, 0, 32'd5, 0);
        send_beat(CMD_PUSH, 0, 32'd7, 0);
        send_beat(CMD_ADD, 1, 0, 0);
        send_beat(CMD_ADD, 3, 32'd1, 0);
        send_beat(CMD_ADD, 0, 32'd2, 0);
        send_beat(CMD_READ, 2, 0, 0);
        send_beat(CMD_PREFIX, 2, 0, 0);
        send_beat(CMD_PREFIX, 10'h3FF, 0, 0);
        send_beat(CMD_TOTAL, 0, 0, 0);
        send_beat(CMD_FIND, 0, 0, 32'd2);
        send_beat(CMD_FIND, 0, 0, 32'hFFFF_FFFF);
        send_beat(CMD_FIND, 0, 0, 32'd0);
        send_beat(CMD_POP, 0, 0, 0);
        send_beat(CMD_CLEAR, 0, 0, 0);
        send_beat(CMD_CLEAR, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_fill_to_capacity();
        // small widths keep the total below wrap so finds hit real entries
        for (int i = 0; i < CAP; i++) send_beat(CMD_PUSH, 0, $urandom_range(1, 9), 0);
        send_beat(CMD_PUSH, 0, 32'd3, 0);
        send_beat(CMD_READ, 10'h3FF, 0, 0);
        send_beat(CMD_PREFIX, 10'h3FF, 0, 0);
        send_beat(CMD_FIND, 0, 0, sum_below(CAP) - 1);
        send_beat(CMD_ADD, 10'h3FF, 32'hFFFF_FFFF, 0);
        send_beat(CMD_TOTAL, 0, 0, 0);
        drain_results();
        send_beat(CMD_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random_mix(int n_items);
        int burst;
        burst = 0;
        for (int i = 0; i < n_items; i++) begin
            logic [2:0]  op;
            logic [9:0]  idx;
            logic [31:0] off, tot;
            int pick;
            if (burst == 0) begin
                repeat ($urandom_range(0, 6)) @(negedge aclk);
                burst = $urandom_range(1, 30);
            end
            burst--;
            pick = $urandom_range(0, 99);
            if (pick < 30) op = CMD_PUSH;
            else if (pick < 42) op = CMD_ADD;
            else if (pick < 54) op = CMD_READ;
            else if (pick < 66) op = CMD_PREFIX;
            else if (pick < 84) op = CMD_FIND;
            else if (pick < 89) op = CMD_TOTAL;
            else if (pick < 98) op = CMD_POP;
            else op = CMD_CLEAR;
            if (n_entries > 0 && $urandom_range(0, 7) != 0)
                idx = 10'($urandom_range(0, n_entries - 1));
            else idx = 10'($urandom());
            tot = sum_below(n_entries);
            if (tot != 0 && $urandom_range(0, 5) != 0) off = $urandom_range(0, tot - 1);
            else off = $urandom();
            send_beat(op, idx, ($urandom_range(0, 19) == 0) ? 32'd0 : rand_width(), off);
        end
    endtask

    task automatic test_backpressure();
        hold_sink = 1;
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_sink = 0;
            end
            for (int i = 0; i < 20; i++) send_beat(CMD_PUSH, 0, rand_width(), 0);
        join
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_fill_to_capacity();
        test_backpressure();
        test_random_mix(260);
        drain_results();
        sink_free = 1;
        test_random_mix(260);
        sink_free = 0;
        drain_results();
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
